FILE: src/rar_pkg.sv
// shared constants for the rational add and reduce block
`default_nettype none
package rar_pkg;

  localparam int IN_W       = 16;
  localparam int IN_TDATA_W = ((4 * IN_W + 7) / 8) * 8;
  localparam int SUM_W      = 2 * IN_W;
  localparam int NUM_OUT_W  = 33;
  localparam int DEN_OUT_W  = 31;
  localparam int OUT_TDATA_W = NUM_OUT_W + DEN_OUT_W;
  localparam int NEG_W      = ((SUM_W > NUM_OUT_W) ? SUM_W : NUM_OUT_W) + 1;
  localparam int DEN_EXT_W  = ((SUM_W > DEN_OUT_W) ? SUM_W : DEN_OUT_W) + 1;
  localparam int CNT_W      = $clog2(SUM_W + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(SUM_W);

endpackage
`default_nettype wire

FILE: src/rar_divu.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module rar_divu (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rar_pkg::SUM_W-1:0]  dividend,
  input  wire logic [rar_pkg::SUM_W-1:0]  divisor,
  output logic                            done,
  output logic [rar_pkg::SUM_W-1:0]       quot,
  output logic [rar_pkg::SUM_W-1:0]       rem
);

  logic [rar_pkg::SUM_W-1:0] quo_r, quo_nxt;
  logic [rar_pkg::SUM_W-1:0] rem_r, rem_nxt;
  logic [rar_pkg::SUM_W-1:0] dvs_r, dvs_nxt;
  logic [rar_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic [rar_pkg::SUM_W:0]   shifted;
  logic [rar_pkg::SUM_W:0]   diff;

  assign shifted = {rem_r, quo_r[rar_pkg::SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = rar_pkg::CNT_LOAD;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == rar_pkg::CNT_W'(1));
      if (!diff[rar_pkg::SUM_W]) begin
        rem_nxt = diff[rar_pkg::SUM_W-1:0];
        quo_nxt = {quo_r[rar_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[rar_pkg::SUM_W-1:0];
        quo_nxt = {quo_r[rar_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

FILE: src/rational_add_reduce.sv
// top level: sum of two signed fractions reduced to lowest terms
// the gcd is found by euclid remainder steps, then both magnitudes are divided by it
// a zero denominator skips straight to the output with den_zero set
// each remainder and each final quotient is one run of the shared divider
// one item at a time; a new item may be taken while the previous result waits
// synchronous active-low reset returns the sequencer to idle and drops out_tvalid
`default_nettype none
module rational_add_reduce (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // num_a, den_a, num_b, den_b
  input  wire logic [rar_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // sum_num, sum_den
  output logic [rar_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // den_zero
  output logic                                   out_tuser
);

  localparam int InW  = rar_pkg::IN_W;
  localparam int SumW = rar_pkg::SUM_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL1 = 9'b000000010,
    S_MUL2 = 9'b000000100,
    S_MUL3 = 9'b000001000,
    S_SUM  = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_QN   = 9'b001000000,
    S_QD   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [InW-1:0]  mna_r, mna_nxt, mda_r, mda_nxt, mnb_r, mnb_nxt, mdb_r, mdb_nxt;
  logic            sna_r, sna_nxt, sda_r, sda_nxt, snb_r, snb_nxt, sdb_r, sdb_nxt;
  logic [SumW-1:0] m1_r, m1_nxt, m2_r, m2_nxt, dmag_r, dmag_nxt, nmag_r, nmag_nxt;
  logic [SumW-1:0] a_r, a_nxt, b_r, b_nxt, qn_r, qn_nxt, qd_r, qd_nxt;
  logic            nneg_r, nneg_nxt, err_r, err_nxt, go_r, go_nxt;
  logic            out_valid_r, out_valid_nxt, den_zero_r, den_zero_nxt;
  logic [rar_pkg::NUM_OUT_W-1:0] sum_num_r, sum_num_nxt;
  logic [rar_pkg::DEN_OUT_W-1:0] sum_den_r, sum_den_nxt;

  logic [InW-1:0]  f_na, f_da, f_nb, f_db;
  logic [InW-1:0]  mul_x, mul_y;
  logic [SumW-1:0] mul_p;
  logic            div_done;
  logic [SumW-1:0] div_quot, div_rem;
  logic            s1, s2, sum_neg;
  logic [SumW-1:0] sum_mag;
  logic [rar_pkg::NEG_W-1:0]     num_ext, num_sgn;
  logic [rar_pkg::DEN_EXT_W-1:0] den_ext;

  assign f_na = in_tdata[InW-1:0];
  assign f_da = in_tdata[2*InW-1:InW];
  assign f_nb = in_tdata[3*InW-1:2*InW];
  assign f_db = in_tdata[4*InW-1:3*InW];

  // shared multiplier
  always_comb begin
    mul_x = mna_r;
    mul_y = mdb_r;
    if (state_r == S_MUL2) begin
      mul_x = mda_r;
      mul_y = mnb_r;
    end else if (state_r == S_MUL3) begin
      mul_x = mda_r;
      mul_y = mdb_r;
    end
  end

  assign mul_p = {{InW{1'b0}}, mul_x} * {{InW{1'b0}}, mul_y};

  rar_divu u_divu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r),
    .dividend (a_r),
    .divisor  (b_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // signed sum of the cross products
  always_comb begin
    s1 = (sna_r ^ sdb_r) && (m1_r != '0);
    s2 = (sda_r ^ snb_r) && (m2_r != '0);
    if (s1 == s2) begin
      sum_mag = m1_r + m2_r;
      sum_neg = s1;
    end else if (m1_r >= m2_r) begin
      sum_mag = m1_r - m2_r;
      sum_neg = s1;
    end else begin
      sum_mag = m2_r - m1_r;
      sum_neg = s2;
    end
    if (sda_r ^ sdb_r) begin
      sum_neg = !sum_neg;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  assign num_ext = {{(rar_pkg::NEG_W - SumW){1'b0}}, qn_r};
  assign num_sgn = nneg_r ? (~num_ext + 1'b1) : num_ext;
  assign den_ext = {{(rar_pkg::DEN_EXT_W - SumW){1'b0}}, qd_r};

  always_comb begin
    state_nxt     = state_r;
    mna_nxt = mna_r;  mda_nxt = mda_r;  mnb_nxt = mnb_r;  mdb_nxt = mdb_r;
    sna_nxt = sna_r;  sda_nxt = sda_r;  snb_nxt = snb_r;  sdb_nxt = sdb_r;
    m1_nxt = m1_r;  m2_nxt = m2_r;  dmag_nxt = dmag_r;  nmag_nxt = nmag_r;
    a_nxt = a_r;  b_nxt = b_r;  qn_nxt = qn_r;  qd_nxt = qd_r;
    nneg_nxt      = nneg_r;
    err_nxt       = err_r;
    go_nxt        = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    sum_num_nxt   = sum_num_r;
    sum_den_nxt   = sum_den_r;
    den_zero_nxt  = den_zero_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          sna_nxt = f_na[InW-1];
          sda_nxt = f_da[InW-1];
          snb_nxt = f_nb[InW-1];
          sdb_nxt = f_db[InW-1];
          mna_nxt = f_na[InW-1] ? (~f_na + 1'b1) : f_na;
          mda_nxt = f_da[InW-1] ? (~f_da + 1'b1) : f_da;
          mnb_nxt = f_nb[InW-1] ? (~f_nb + 1'b1) : f_nb;
          mdb_nxt = f_db[InW-1] ? (~f_db + 1'b1) : f_db;
          if ((f_da == '0) || (f_db == '0)) begin
            err_nxt   = 1'b1;
            qn_nxt    = '0;
            qd_nxt    = '0;
            nneg_nxt  = 1'b0;
            state_nxt = S_OUT;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        m1_nxt    = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        m2_nxt    = mul_p;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        dmag_nxt  = mul_p;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        nmag_nxt  = sum_mag;
        nneg_nxt  = sum_neg;
        a_nxt     = sum_mag;
        b_nxt     = dmag_r;
        go_nxt    = 1'b1;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        if (div_done) begin
          go_nxt = 1'b1;
          if (div_rem == '0) begin
            a_nxt     = nmag_r;
            state_nxt = S_QN;
          end else begin
            a_nxt = b_r;
            b_nxt = div_rem;
          end
        end
      end
      S_QN: begin
        if (div_done) begin
          qn_nxt    = div_quot;
          a_nxt     = dmag_r;
          go_nxt    = 1'b1;
          state_nxt = S_QD;
        end
      end
      S_QD: begin
        if (div_done) begin
          qd_nxt    = div_quot;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          sum_num_nxt   = num_sgn[rar_pkg::NUM_OUT_W-1:0];
          sum_den_nxt   = den_ext[rar_pkg::DEN_OUT_W-1:0];
          den_zero_nxt  = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mna_r <= mna_nxt;  mda_r <= mda_nxt;  mnb_r <= mnb_nxt;  mdb_r <= mdb_nxt;
    sna_r <= sna_nxt;  sda_r <= sda_nxt;  snb_r <= snb_nxt;  sdb_r <= sdb_nxt;
    m1_r <= m1_nxt;  m2_r <= m2_nxt;  dmag_r <= dmag_nxt;  nmag_r <= nmag_nxt;
    a_r <= a_nxt;  b_r <= b_nxt;  qn_r <= qn_nxt;  qd_r <= qd_nxt;
    nneg_r     <= nneg_nxt;
    err_r      <= err_nxt;
    sum_num_r  <= sum_num_nxt;
    sum_den_r  <= sum_den_nxt;
    den_zero_r <= den_zero_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {sum_den_r, sum_num_r};
  assign out_tuser  = den_zero_r;

endmodule
`default_nettype wire
